// ===== rtl/rms_pkg.sv =====
// Shared types and constants for the robot mode supervisor.
`timescale 1ns / 1ps
`default_nettype none

package rms_pkg;

    // Fault word geometry.
    localparam int unsigned FAULT_BITS = 64;
    localparam logic [63:0] FW_KEEP =
        (FAULT_BITS >= 64) ? 64'hffff_ffff_ffff_ffff : ((64'd1 << FAULT_BITS) - 64'd1);
    localparam int unsigned CD_SHIFT = FAULT_BITS - 4;
    localparam logic [63:0] CD_MASK = 64'hf << CD_SHIFT;

    localparam int unsigned TIME_W  = 63;
    localparam int unsigned GRACE_W = 24;
    localparam int unsigned USEC_PER_SEC = 1000000;

    // Event time is tracked modulo 16 s: the countdown digit only needs
    // floor(rem / 1 s) mod 16. 16e6 = 2^9 * 31250.
    localparam int unsigned RES_MOD   = 16 * USEC_PER_SEC;
    localparam int unsigned RES_W     = 24;
    localparam int unsigned RES_LO_W  = 9;
    localparam int unsigned RES_ODD   = RES_MOD >> RES_LO_W;
    localparam int unsigned ODD_W     = RES_W - RES_LO_W;
    localparam int unsigned OFS_W     = RES_W + 1;
    localparam int unsigned V_W       = OFS_W + 1;
    localparam int unsigned X_W       = TIME_W - RES_LO_W;

    // Chunk weights 2^(16k) mod RES_ODD for the first fold.
    localparam longint unsigned K1 = (64'd1 << 16) % RES_ODD;
    localparam longint unsigned K2 = (64'd1 << 32) % RES_ODD;
    localparam longint unsigned K3 = (64'd1 << 48) % RES_ODD;
    localparam int unsigned SUM_W  = 33;
    localparam int unsigned FOLD_W = 29;

    // Reciprocal for the final reduction, floor(2^44 / RES_ODD).
    localparam int unsigned RECIP_SHIFT = 44;
    localparam int unsigned RECIP_W     = 30;
    localparam longint unsigned RECIP   = (64'd1 << RECIP_SHIFT) / RES_ODD;
    localparam int unsigned PROD_W      = FOLD_W + RECIP_W;

    // Register map index (byte address / 8).
    localparam logic [2:0] REG_BLOCK_MANUAL  = 3'd0;
    localparam logic [2:0] REG_BLOCK_STANDBY = 3'd1;
    localparam logic [2:0] REG_OK_MANUAL     = 3'd2;
    localparam logic [2:0] REG_OK_STANDBY    = 3'd3;
    localparam logic [2:0] REG_DEV_MODE      = 3'd4;
    localparam logic [2:0] REG_GRACE         = 3'd5;

    typedef enum logic [2:0] {
        MODE_UNDEF   = 3'd0,
        MODE_RUN     = 3'd1,
        MODE_STANDBY = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_MANUAL  = 3'd4,
        MODE_ERROR   = 3'd5
    } t_mode;

    localparam logic CMD_STATE   = 1'b0;
    localparam logic CMD_PUBLISH = 1'b1;

    typedef struct packed {
        logic [63:0]        blk_manual;
        logic [63:0]        blk_standby;
        logic [63:0]        ok_manual;
        logic [63:0]        ok_standby;
        logic               dev_mode;
        logic [GRACE_W-1:0] grace;
    } t_cfg;

    typedef struct packed {
        logic              cmd;
        logic [2:0]        req;
        logic [TIME_W-1:0] evt;
        logic [63:0]       add;
        logic [63:0]       clr;
    } t_item;

    typedef struct packed {
        t_mode             mode;
        logic [63:0]       fw;
        logic [TIME_W-1:0] status;
        logic [RES_W-1:0]  status_res;
        logic [TIME_W-1:0] prev;
        logic [RES_W-1:0]  prev_res;
    } t_state;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] faults;
        logic        changed;
        logic [63:0] rejected;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rms_decide.sv =====
// Mode decision: next supervisor state and result for one request.
`timescale 1ns / 1ps
`default_nettype none

module rms_decide (
    input  rms_pkg::t_state                  i_state,
    input  rms_pkg::t_cfg                    i_cfg,
    input  rms_pkg::t_item                   i_item,
    input  logic [rms_pkg::RES_W-1:0]        i_tres,
    input  logic [rms_pkg::OFS_W-1:0]        i_ofs,
    output rms_pkg::t_state                  o_state,
    output rms_pkg::t_result                 o_res
);

    function automatic rms_pkg::t_state set_mode(
        input rms_pkg::t_state                 cur,
        input rms_pkg::t_mode                  m,
        input logic [63:0]                     fw,
        input logic [rms_pkg::TIME_W-1:0]      t,
        input logic [rms_pkg::RES_W-1:0]       tres
    );
        rms_pkg::t_state s;
        s = cur;
        if (m != cur.mode) begin
            s.prev     = cur.status;
            s.prev_res = cur.status_res;
        end
        s.status     = t;
        s.status_res = tres;
        s.mode       = m;
        s.fw         = fw;
        return s;
    endfunction

    logic [63:0]              f;
    logic [rms_pkg::V_W-1:0]  v;
    logic [rms_pkg::RES_W-1:0] vr;
    logic [3:0]               cnt;
    logic [63:0]              lim;
    logic                     below;
    logic                     run_win;
    logic [63:0]              nf;
    logic                     standby_ok;

    assign f = ((i_state.fw | i_item.add) & ~i_item.clr) & rms_pkg::FW_KEEP;
    assign standby_ok = (f & i_cfg.blk_standby) == 64'd0;

    // Countdown digit: (grace + prev - t) mod 16 s, in whole seconds.
    assign v = rms_pkg::V_W'(i_state.prev_res) + rms_pkg::V_W'(i_ofs);

    always_comb begin
        if (v >= rms_pkg::V_W'(2 * rms_pkg::RES_MOD)) begin
            vr = rms_pkg::RES_W'(v - rms_pkg::V_W'(2 * rms_pkg::RES_MOD));
        end else if (v >= rms_pkg::V_W'(rms_pkg::RES_MOD)) begin
            vr = rms_pkg::RES_W'(v - rms_pkg::V_W'(rms_pkg::RES_MOD));
        end else begin
            vr = rms_pkg::RES_W'(v);
        end
    end

    always_comb begin
        cnt = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (vr >= rms_pkg::RES_W'(k * rms_pkg::USEC_PER_SEC)) begin
                cnt = 4'(k);
            end
        end
    end

    assign lim     = 64'(i_state.prev) + 64'(i_cfg.grace);
    assign below   = {1'b0, i_item.evt} < lim;
    assign run_win = {1'b0, i_item.evt} < (lim + 64'(rms_pkg::USEC_PER_SEC));
    assign nf = ((f & ~rms_pkg::CD_MASK) | (64'(cnt) << rms_pkg::CD_SHIFT))
                & rms_pkg::FW_KEEP;

    always_comb begin
        rms_pkg::t_state nxt;
        logic            done;
        logic [63:0]     rej;
        logic [63:0]     b;

        nxt  = i_state;
        done = 1'b0;
        rej  = 64'd0;
        b    = f & i_cfg.blk_manual;

        if (i_item.cmd == rms_pkg::CMD_PUBLISH) begin
            nxt.status     = i_item.evt;
            nxt.status_res = i_tres;
        end else begin
            if (i_item.req == rms_pkg::MODE_MANUAL && i_state.mode == rms_pkg::MODE_STOP) begin
                if (b == 64'd0) begin
                    nxt  = set_mode(i_state, rms_pkg::MODE_MANUAL, f, i_item.evt, i_tres);
                    done = 1'b1;
                end else begin
                    rej = b;
                end
            end

            if (!done) begin
                if (standby_ok) begin
                    if (i_item.req == rms_pkg::MODE_UNDEF
                            && i_state.mode == rms_pkg::MODE_STANDBY) begin
                        if (below) begin
                            nxt  = set_mode(i_state, rms_pkg::MODE_STANDBY, nf,
                                            i_item.evt, i_tres);
                            done = 1'b1;
                        end else if (run_win) begin
                            nxt  = set_mode(i_state, rms_pkg::MODE_RUN, f, i_item.evt, i_tres);
                            done = 1'b1;
                        end
                    end
                    if (!done && i_item.req == rms_pkg::MODE_RUN
                            && i_state.mode == rms_pkg::MODE_RUN) begin
                        done = 1'b1;
                    end
                    if (!done && i_item.req == rms_pkg::MODE_RUN
                            && (i_state.mode == rms_pkg::MODE_STOP
                                || i_state.mode == rms_pkg::MODE_STANDBY)) begin
                        nxt  = set_mode(i_state, rms_pkg::MODE_STANDBY, f, i_item.evt, i_tres);
                        done = 1'b1;
                    end
                end else if (i_item.req == rms_pkg::MODE_RUN
                        && (i_state.mode == rms_pkg::MODE_STOP
                            || i_state.mode == rms_pkg::MODE_STANDBY)) begin
                    rej = f & i_cfg.blk_standby;
                end
            end

            if (!done && i_item.req != rms_pkg::MODE_STOP) begin
                if ((i_state.mode == rms_pkg::MODE_MANUAL || i_state.mode == rms_pkg::MODE_RUN)
                        && (f & i_cfg.ok_manual) == 64'd0) begin
                    done = 1'b1;
                end else if (i_state.mode == rms_pkg::MODE_STANDBY
                        && (f & i_cfg.ok_standby) == 64'd0) begin
                    done = 1'b1;
                end else if (i_cfg.dev_mode && f == 64'd0) begin
                    nxt.fw = 64'd0;
                    done   = 1'b1;
                end
            end

            if (!done && i_item.req != rms_pkg::MODE_UNDEF) begin
                nxt = set_mode(i_state, rms_pkg::MODE_STOP, f, i_item.evt, i_tres);
            end
        end

        o_state        = nxt;
        o_res.mode     = nxt.mode;
        o_res.faults   = nxt.fw & rms_pkg::FW_KEEP;
        o_res.changed  = nxt.mode != i_state.mode;
        o_res.rejected = rej & rms_pkg::FW_KEEP;
    end

endmodule

`default_nettype wire

// ===== rtl/robot_mode_supervisor_unit.sv =====
// Top level of the robot mode supervisor: request pipeline, state and APB registers.
`timescale 1ns / 1ps
`default_nettype none

// Safety mode supervisor. Each request is either a state command (merge and
// clear faults, then decide among stop, manual, standby and run against the
// four fault masks) or a publish that restamps the status time. Every request
// gives exactly one result. Requests flow through a six-register pipeline:
// input register, three stages that reduce the event time modulo 16 s
// (chunk products, a fold, a reciprocal multiply), a stage with the
// remainder correction, then the decision stage that updates mode, fault
// word and timestamps and loads the result register. One request is taken
// per cycle whenever the result side keeps up; the decision stage updates
// the state as it loads each result, which is what allows that rate. Each
// stage holds its request until the next one has room, so requests keep
// entering while a result waits, until every stage is full.
// Config registers sit at byte address 8*i on a 64-bit APB port; write them
// only while no request is in flight.

module robot_mode_supervisor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [2:0]  i_requested_state,
    input  logic [62:0] i_event_time,
    input  logic [63:0] i_added_faults,
    input  logic [63:0] i_cleared_faults,

    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_mode_now,
    output logic [63:0] o_faults_now,
    output logic        o_mode_changed,
    output logic [63:0] o_rejected_by,

    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // ---------------- config registers ----------------
    rms_pkg::t_cfg r_cfg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                rms_pkg::REG_BLOCK_MANUAL:  r_cfg.blk_manual  <= pwdata;
                rms_pkg::REG_BLOCK_STANDBY: r_cfg.blk_standby <= pwdata;
                rms_pkg::REG_OK_MANUAL:     r_cfg.ok_manual   <= pwdata;
                rms_pkg::REG_OK_STANDBY:    r_cfg.ok_standby  <= pwdata;
                rms_pkg::REG_DEV_MODE:      r_cfg.dev_mode    <= pwdata[0];
                rms_pkg::REG_GRACE:         r_cfg.grace       <= pwdata[rms_pkg::GRACE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            rms_pkg::REG_BLOCK_MANUAL:  prdata = r_cfg.blk_manual;
            rms_pkg::REG_BLOCK_STANDBY: prdata = r_cfg.blk_standby;
            rms_pkg::REG_OK_MANUAL:     prdata = r_cfg.ok_manual;
            rms_pkg::REG_OK_STANDBY:    prdata = r_cfg.ok_standby;
            rms_pkg::REG_DEV_MODE:      prdata = 64'(r_cfg.dev_mode);
            rms_pkg::REG_GRACE:         prdata = 64'(r_cfg.grace);
            default:                    prdata = 64'd0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // A stage loads when it is empty or its contents move on this cycle.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_out_vld;
    logic adv1, adv2, adv3, adv4, adv5, adv_out;

    assign adv_out = !r_out_vld || i_ready;
    assign adv5    = !r_v5 || adv_out;
    assign adv4    = !r_v4 || adv5;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv1)    r_v1      <= i_valid;
            if (adv2)    r_v2      <= r_v1;
            if (adv3)    r_v3      <= r_v2;
            if (adv4)    r_v4      <= r_v3;
            if (adv5)    r_v5      <= r_v4;
            if (adv_out) r_out_vld <= r_v5;
        end
    end

    // ---------------- stage 1: input register ----------------
    rms_pkg::t_item r_it1, r_it2, r_it3, r_it4, r_it5;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_it1.cmd <= i_command;
            r_it1.req <= i_requested_state;
            r_it1.evt <= i_event_time;
            r_it1.add <= i_added_faults;
            r_it1.clr <= i_cleared_faults;
        end
    end

    // ---------------- stage 2: chunk products ----------------
    // x = evt >> 9 is reduced mod 31250 by weighting 16-bit chunks.
    logic [rms_pkg::X_W-1:0]      x1;
    logic [rms_pkg::SUM_W-1:0]    n_sum2;
    logic [rms_pkg::SUM_W-1:0]    r_sum2;

    assign x1 = r_it1.evt[rms_pkg::TIME_W-1:rms_pkg::RES_LO_W];
    assign n_sum2 = rms_pkg::SUM_W'(x1[15:0])
                  + rms_pkg::SUM_W'(x1[31:16]) * rms_pkg::SUM_W'(rms_pkg::K1)
                  + rms_pkg::SUM_W'(x1[47:32]) * rms_pkg::SUM_W'(rms_pkg::K2)
                  + rms_pkg::SUM_W'(x1[rms_pkg::X_W-1:48]) * rms_pkg::SUM_W'(rms_pkg::K3);

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_it2  <= r_it1;
            r_sum2 <= n_sum2;
        end
    end

    // ---------------- stage 3: second fold ----------------
    logic [rms_pkg::FOLD_W-1:0] n_fold3;
    logic [rms_pkg::FOLD_W-1:0] r_fold3;

    assign n_fold3 = rms_pkg::FOLD_W'(r_sum2[15:0])
                   + rms_pkg::FOLD_W'(r_sum2[rms_pkg::SUM_W-1:16])
                     * rms_pkg::FOLD_W'(rms_pkg::K1);

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_it3   <= r_it2;
            r_fold3 <= n_fold3;
        end
    end

    // ---------------- stage 4: reciprocal quotient ----------------
    logic [rms_pkg::PROD_W-1:0] prod3;
    logic [rms_pkg::FOLD_W-1:0] r_fold4;
    logic [rms_pkg::ODD_W-1:0]  r_quo4;

    assign prod3 = rms_pkg::PROD_W'(r_fold3) * rms_pkg::PROD_W'(rms_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_it4   <= r_it3;
            r_fold4 <= r_fold3;
            r_quo4  <= prod3[rms_pkg::PROD_W-1:rms_pkg::RECIP_SHIFT];
        end
    end

    // ---------------- stage 5: remainder, countdown offset ----------------
    // Quotient estimate is low by at most one: one conditional subtract.
    logic [rms_pkg::FOLD_W-1:0]  rem_full;
    logic [rms_pkg::ODD_W:0]     rem_raw;
    logic [rms_pkg::ODD_W-1:0]   rem_odd;
    logic [rms_pkg::RES_W-1:0]   n_tres5;
    logic [rms_pkg::GRACE_W-1:0] grace_res;
    logic [rms_pkg::OFS_W-1:0]   n_ofs5;
    logic [rms_pkg::RES_W-1:0]   r_tres5;
    logic [rms_pkg::OFS_W-1:0]   r_ofs5;

    assign rem_full = r_fold4 - rms_pkg::FOLD_W'(r_quo4) * rms_pkg::FOLD_W'(rms_pkg::RES_ODD);
    assign rem_raw  = rem_full[rms_pkg::ODD_W:0];
    assign rem_odd  = (rem_raw >= (rms_pkg::ODD_W+1)'(rms_pkg::RES_ODD))
                    ? rms_pkg::ODD_W'(rem_raw - (rms_pkg::ODD_W+1)'(rms_pkg::RES_ODD))
                    : rem_raw[rms_pkg::ODD_W-1:0];
    assign n_tres5  = {rem_odd, r_it4.evt[rms_pkg::RES_LO_W-1:0]};

    // grace + 16 s - (t mod 16 s), with grace first brought below 16 s
    assign grace_res = (r_cfg.grace >= rms_pkg::GRACE_W'(rms_pkg::RES_MOD))
                     ? r_cfg.grace - rms_pkg::GRACE_W'(rms_pkg::RES_MOD)
                     : r_cfg.grace;
    assign n_ofs5 = rms_pkg::OFS_W'(grace_res) + rms_pkg::OFS_W'(rms_pkg::RES_MOD)
                  - rms_pkg::OFS_W'(n_tres5);

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_it5   <= r_it4;
            r_tres5 <= n_tres5;
            r_ofs5  <= n_ofs5;
        end
    end

    // ---------------- decision stage and supervisor state ----------------
    rms_pkg::t_state  r_state;
    rms_pkg::t_state  n_state;
    rms_pkg::t_result n_res;
    rms_pkg::t_result r_res;

    rms_decide u_decide (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (r_it5),
        .i_tres  (r_tres5),
        .i_ofs   (r_ofs5),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= rms_pkg::MODE_STOP;
            r_state.fw         <= '0;
            r_state.status     <= '0;
            r_state.status_res <= '0;
            r_state.prev       <= '0;
            r_state.prev_res   <= '0;
        end else if (adv_out && r_v5) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_v5) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_mode_now     = r_res.mode;
    assign o_faults_now   = r_res.faults;
    assign o_mode_changed = r_res.changed;
    assign o_rejected_by  = r_res.rejected;

endmodule

`default_nettype wire
